[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, suspended while reset is applied.
`define BFPA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bfpa: property failed");
// Checked on every rising edge of clk, reset included.
`define BFPA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bfpa: property failed");
`else
`define BFPA_ASSERT(lbl, prop)
`define BFPA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hdl/bfpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Types, codes and defaults shared by the page allocator modules.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int DEF_PAGES       = 4096;
	localparam int DEF_MAX_EXTENTS = 64;
	localparam int CFG_W           = 13;
	localparam int STAT_W          = 3;

	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_RESERVED = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
	localparam logic [STAT_W-1:0] ST_FEW      = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

	typedef enum logic [1:0] {
		CMD_INIT,
		CMD_ALLOC,
		CMD_FREE,
		CMD_MERGE
	} cmd_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT_SET,
		S_ACHK,
		S_SCAN_RD,
		S_SCAN_EV,
		S_AFIN1,
		S_AFIN2,
		S_AFIN3,
		S_SHDN_RD,
		S_SHDN_WR,
		S_FRD,
		S_FCHK,
		S_POS_RD,
		S_POS_EV,
		S_SHUP_RD,
		S_SHUP_WR,
		S_INSERT,
		S_MSTART,
		S_MLD0,
		S_MRD1,
		S_MEV1,
		S_MJOIN,
		S_DONE
	} state_t;

endpackage

[hdl/best_fit_page_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_page_allocator_top
// Best-fit page allocator over an address-ordered table of free extents.
// ----------------------------------------------------------------------------
// One command item is taken at a time and answered by exactly one result item.
// After reset the block sweeps the per-page length store to zero before it is
// ready; an init command repeats that sweep and then builds at most one free
// extent. All other commands run on a small sequencer that drives one shared
// adder and one extent RAM port per cycle, each table entry taking a read state
// and then a use or write state. An allocate walks all N extents to find the
// best fit, then shifts the later entries down when an exact fit removes the
// entry; a free walks the table to find its place and shifts the later entries
// up to open a gap. A merge walks the table, and every join also shifts the
// rest of the table down by one.
// The result sits in an output register, so the next item is accepted
// while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module best_fit_page_allocator_top
	import bfpa_pkg::*;
#(
	parameter int PAGES       = DEF_PAGES,
	parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
	localparam int PW   = $clog2(PAGES),
	localparam int LW   = PW + 1,
	localparam int CW   = $clog2(MAX_EXTENTS + 1),
	localparam int IN_W  = ((2 + LW + PW + 7) / 8) * 8,
	localparam int OUT_W = ((STAT_W + PW + LW + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write port.
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	// Command items.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // cmd, count, start_page, zero fill
	// Result items.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status, page_index, free_count, block_count
);

	`include "assert_macros.svh"

	localparam int EAW = $clog2(MAX_EXTENTS);
	localparam int EW  = PW + LW;
	localparam int VW  = ((LW > CFG_W) ? LW : CFG_W) + 1;

	// Control state.
	state_t           state_q, state_d, ret_q;
	logic [CW-1:0]    total_q;
	logic [LW-1:0]    pf_q;
	logic [PW-1:0]    clr_q;
	logic             init_q;
	logic             m_tvalid_q;
	logic [CFG_W-1:0] tot_cfg_q, res_cfg_q;

	// Working registers.
	logic [LW-1:0]      cnt_q;
	logic [PW-1:0]      sp_q;
	logic [LW-1:0]      pfn_q;
	logic [CW-1:0]      i_q, sh_q, best_q;
	logic               found_q;
	logic [PW-1:0]      best_s_q;
	logic [LW-1:0]      best_l_q, diff_q, n_q;
	logic [PW-1:0]      cur_s_q;
	logic [LW-1:0]      cur_l_q, nxt_l_q;
	logic [STAT_W-1:0]  st_q;
	logic [PW-1:0]      where_q;
	logic [OUT_W-1:0]   out_q;

	// Memories and shared unit.
	logic           ext_we, ext_re;
	logic [EAW-1:0] ext_waddr, ext_raddr;
	logic [EW-1:0]  ext_wdata, ext_rdata;
	logic           al_we, al_re;
	logic [PW-1:0]  al_waddr, al_raddr;
	logic [LW-1:0]  al_wdata, al_rdata;
	alu_op_t        alu_op;
	logic [VW-1:0]  alu_a, alu_b, alu_res;
	logic           borrow;

	logic [PW-1:0] rd_s;
	logic [LW-1:0] rd_l;
	logic [VW-1:0] tot_eff;
	logic          done_take;
	logic [CW-1:0] sh_inc, i_inc, sh_dec;

	assign rd_s    = ext_rdata[EW-1:LW];
	assign rd_l    = ext_rdata[LW-1:0];
	assign borrow  = alu_res[VW-1];
	assign tot_eff = (VW'(tot_cfg_q) > VW'(PAGES)) ? VW'(PAGES) : VW'(tot_cfg_q);
	assign sh_inc  = sh_q + 1'b1;
	assign sh_dec  = sh_q - 1'b1;
	assign i_inc   = i_q + 1'b1;
	assign done_take = !m_tvalid_q || m_tready;

	bfpa_ram #(.DEPTH(MAX_EXTENTS), .WIDTH(EW)) u_ext (
		.clk(clk), .we(ext_we), .waddr(ext_waddr), .wdata(ext_wdata),
		.re(ext_re), .raddr(ext_raddr), .rdata(ext_rdata)
	);

	bfpa_ram #(.DEPTH(PAGES), .WIDTH(LW)) u_alen (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.re(al_re), .raddr(al_raddr), .rdata(al_rdata)
	);

	bfpa_alu #(.W(VW)) u_alu (
		.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == PW'(PAGES - 1)) state_d = init_q ? S_INIT_SET : S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (cmd_t'(s_tdata[1:0]))
						CMD_INIT:  state_d = S_CLEAR;
						CMD_ALLOC: state_d = S_ACHK;
						CMD_FREE:  state_d = S_FRD;
						default:   state_d = S_MSTART;
					endcase
				end
			end
			S_INIT_SET: state_d = S_DONE;
			S_ACHK: begin
				if (cnt_q == '0 || borrow) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (i_q == total_q) state_d = found_q ? S_AFIN1 : S_DONE;
				else state_d = S_SCAN_EV;
			end
			S_SCAN_EV: state_d = S_SCAN_RD;
			S_AFIN1: state_d = (alu_res == '0) ? S_SHDN_RD : S_AFIN2;
			S_AFIN2: state_d = S_AFIN3;
			S_AFIN3: state_d = S_DONE;
			S_SHDN_RD: state_d = (sh_inc >= total_q) ? ret_q : S_SHDN_WR;
			S_SHDN_WR: state_d = S_SHDN_RD;
			S_FRD: state_d = (LW'(sp_q) >= LW'(PAGES)) ? S_DONE : S_FCHK;
			S_FCHK: begin
				if (al_rdata == '0 || total_q >= CW'(MAX_EXTENTS)) state_d = S_DONE;
				else state_d = S_POS_RD;
			end
			S_POS_RD: state_d = (i_q == total_q) ? S_SHUP_RD : S_POS_EV;
			S_POS_EV: state_d = borrow ? S_SHUP_RD : S_POS_RD;
			S_SHUP_RD: state_d = (sh_q == i_q) ? S_INSERT : S_SHUP_WR;
			S_SHUP_WR: state_d = S_SHUP_RD;
			S_INSERT: state_d = S_DONE;
			S_MSTART: state_d = (total_q < CW'(2)) ? S_DONE : S_MLD0;
			S_MLD0: state_d = S_MRD1;
			S_MRD1: state_d = (i_inc >= total_q) ? S_DONE : S_MEV1;
			S_MEV1: state_d = (VW'(rd_s) == alu_res) ? S_MJOIN : S_MRD1;
			S_MJOIN: state_d = S_SHDN_RD;
			S_DONE: if (done_take) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory ports and shared-unit operands.
	always_comb begin
		ext_we    = 1'b0;
		ext_waddr = '0;
		ext_wdata = '0;
		ext_re    = 1'b0;
		ext_raddr = '0;
		al_we     = 1'b0;
		al_waddr  = '0;
		al_wdata  = '0;
		al_re     = 1'b0;
		al_raddr  = sp_q;
		alu_op    = ALU_ADD;
		alu_a     = '0;
		alu_b     = '0;
		unique case (state_q)
			S_CLEAR: begin
				al_we    = 1'b1;
				al_waddr = clr_q;
			end
			S_INIT_SET: begin
				alu_op    = ALU_SUB;
				alu_a     = tot_eff;
				alu_b     = VW'(res_cfg_q);
				ext_we    = !borrow && (alu_res != '0);
				ext_wdata = {res_cfg_q[PW-1:0], alu_res[LW-1:0]};
			end
			S_ACHK: begin
				alu_op = ALU_SUB;
				alu_a  = VW'(pf_q);
				alu_b  = VW'(cnt_q);
			end
			S_SCAN_RD: begin
				ext_re    = (i_q != total_q);
				ext_raddr = i_q[EAW-1:0];
			end
			S_SCAN_EV: begin
				alu_op = ALU_SUB;
				alu_a  = VW'(rd_l);
				alu_b  = VW'(cnt_q);
			end
			S_AFIN1: begin
				alu_op = ALU_SUB;
				alu_a  = VW'(best_l_q);
				alu_b  = VW'(cnt_q);
			end
			S_AFIN2: begin
				alu_a     = VW'(best_s_q);
				alu_b     = VW'(cnt_q);
				ext_we    = 1'b1;
				ext_waddr = best_q[EAW-1:0];
				ext_wdata = {alu_res[PW-1:0], diff_q};
			end
			S_AFIN3: begin
				al_we    = 1'b1;
				al_waddr = best_s_q;
				al_wdata = cnt_q;
			end
			S_SHDN_RD: begin
				ext_re    = (sh_inc < total_q);
				ext_raddr = sh_inc[EAW-1:0];
			end
			S_SHDN_WR: begin
				ext_we    = 1'b1;
				ext_waddr = sh_q[EAW-1:0];
				ext_wdata = ext_rdata;
			end
			S_FRD: al_re = 1'b1;
			S_POS_RD: begin
				ext_re    = (i_q != total_q);
				ext_raddr = i_q[EAW-1:0];
			end
			S_POS_EV: begin
				alu_op = ALU_SUB;
				alu_a  = VW'(sp_q);
				alu_b  = VW'(rd_s);
			end
			S_SHUP_RD: begin
				ext_re    = (sh_q != i_q);
				ext_raddr = sh_dec[EAW-1:0];
			end
			S_SHUP_WR: begin
				ext_we    = 1'b1;
				ext_waddr = sh_q[EAW-1:0];
				ext_wdata = ext_rdata;
			end
			S_INSERT: begin
				ext_we    = 1'b1;
				ext_waddr = i_q[EAW-1:0];
				ext_wdata = {sp_q, n_q};
				al_we     = 1'b1;
				al_waddr  = sp_q;
				alu_a     = VW'(pf_q);
				alu_b     = VW'(n_q);
			end
			S_MSTART: begin
				ext_re    = 1'b1;
				ext_raddr = '0;
			end
			S_MRD1: begin
				ext_re    = (i_inc < total_q);
				ext_raddr = i_inc[EAW-1:0];
			end
			S_MEV1: begin
				alu_a = VW'(cur_s_q);
				alu_b = VW'(cur_l_q);
			end
			S_MJOIN: begin
				alu_a     = VW'(cur_l_q);
				alu_b     = VW'(nxt_l_q);
				ext_we    = 1'b1;
				ext_waddr = i_q[EAW-1:0];
				ext_wdata = {cur_s_q, alu_res[LW-1:0]};
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_IDLE;
			total_q    <= '0;
			pf_q       <= '0;
			clr_q      <= '0;
			init_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			tot_cfg_q  <= CFG_W'(4096);
			res_cfg_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_addr == REG_TOTAL) tot_cfg_q <= cfg_wdata;
				else res_cfg_q <= cfg_wdata;
			end
			if (state_q == S_DONE && done_take) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE: begin
					clr_q  <= '0;
					init_q <= 1'b1;
				end
				S_INIT_SET: begin
					if (!borrow && alu_res != '0) begin
						total_q <= CW'(1);
						pf_q    <= alu_res[LW-1:0];
					end else begin
						total_q <= '0;
						pf_q    <= '0;
					end
				end
				S_AFIN1: ret_q <= S_AFIN3;
				S_AFIN3: pf_q <= pfn_q;
				S_SHDN_RD: if (sh_inc >= total_q) total_q <= total_q - 1'b1;
				S_INSERT: begin
					total_q <= total_q + 1'b1;
					pf_q    <= (alu_res > VW'(PAGES)) ? LW'(PAGES) : alu_res[LW-1:0];
				end
				S_MJOIN: ret_q <= S_MRD1;
				default: begin
				end
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cnt_q   <= s_tdata[LW+1:2];
				sp_q    <= s_tdata[LW+PW+1:LW+2];
				st_q    <= ST_OK;
				where_q <= '0;
			end
			S_ACHK: begin
				if (cnt_q == '0) st_q <= ST_ZERO;
				else if (borrow) st_q <= ST_FEW;
				pfn_q   <= alu_res[LW-1:0];
				i_q     <= '0;
				found_q <= 1'b0;
			end
			S_SCAN_RD: if (i_q == total_q && !found_q) st_q <= ST_NOFIT;
			S_SCAN_EV: begin
				if (!borrow && (!found_q || rd_l < best_l_q)) begin
					found_q  <= 1'b1;
					best_q   <= i_q;
					best_s_q <= rd_s;
					best_l_q <= rd_l;
				end
				i_q <= i_inc;
			end
			S_AFIN1: begin
				diff_q <= alu_res[LW-1:0];
				sh_q   <= best_q;
			end
			S_AFIN3: where_q <= best_s_q;
			S_SHDN_WR: sh_q <= sh_inc;
			S_FRD: if (LW'(sp_q) >= LW'(PAGES)) st_q <= ST_NOTALLOC;
			S_FCHK: begin
				n_q <= al_rdata;
				i_q <= '0;
				if (al_rdata == '0) st_q <= ST_NOTALLOC;
				else if (total_q >= CW'(MAX_EXTENTS)) st_q <= ST_FULL;
			end
			S_POS_RD: sh_q <= total_q;
			S_POS_EV: if (!borrow) i_q <= i_inc;
			S_SHUP_WR: sh_q <= sh_dec;
			S_MSTART: i_q <= '0;
			S_MLD0: begin
				cur_s_q <= rd_s;
				cur_l_q <= rd_l;
			end
			S_MEV1: begin
				if (VW'(rd_s) == alu_res) begin
					nxt_l_q <= rd_l;
				end else begin
					cur_s_q <= rd_s;
					cur_l_q <= rd_l;
					i_q     <= i_inc;
				end
			end
			S_MJOIN: begin
				cur_l_q <= alu_res[LW-1:0];
				sh_q    <= i_inc;
			end
			S_DONE: begin
				if (done_take) out_q <= OUT_W'({total_q, pf_q, where_q, st_q});
			end
			default: begin
			end
		endcase
	end

	// Table never holds more extents than it has room for.
	`BFPA_ASSERT(a_total_bound, total_q <= CW'(MAX_EXTENTS))
	// Free page count never exceeds the managed page count.
	`BFPA_ASSERT(a_free_bound, pf_q <= LW'(PAGES))
	// An accepted item always starts work: the block drops ready next cycle.
	`BFPA_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
	// A new result carries one of the defined status codes.
	`BFPA_ASSERT(a_status_code, $rose(m_tvalid) |-> (out_q[STAT_W-1:0] <= ST_FULL))
	// Only a successful allocate reports a page index.
	`BFPA_ASSERT(a_index_zero,
		$rose(m_tvalid) && (out_q[STAT_W-1:0] != ST_OK) |-> (out_q[STAT_W+PW-1:STAT_W] == '0))

endmodule

[hdl/bfpa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bfpa_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_alu
// Shared adder/subtractor; callers zero-extend so the top bit is the borrow.
// ----------------------------------------------------------------------------
module bfpa_alu
	import bfpa_pkg::*;
#(
	parameter int W = 14
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res
);

	always_comb begin
		case (op)
			ALU_SUB: res = a - b;
			default: res = a + b;
		endcase
	end

endmodule
